FILE: hdl/apc_pkg.sv
package apc_pkg;

    // Q16.16 data word and wide accumulator
    typedef logic signed [31:0] q_t;
    typedef logic signed [47:0] acc_t;

    localparam int IDXW      = 4;
    localparam int DIV_STEPS = 48;

    localparam acc_t ACC_MAX = 48'sh0000_7FFF_FFFF;
    localparam acc_t ACC_MIN = 48'shFFFF_8000_0000;
    localparam acc_t ONE_ACC = 48'sh0000_0001_0000;
    localparam q_t   Q_MAX   = 32'sh7FFF_FFFF;
    localparam q_t   Q_MIN   = 32'sh8000_0000;

    // configuration register indexes
    localparam logic [IDXW-1:0] REG_COEF_Y       = 4'd0;
    localparam logic [IDXW-1:0] REG_COEF_Y_PREV  = 4'd1;
    localparam logic [IDXW-1:0] REG_COEF_SP_PREV = 4'd2;
    localparam logic [IDXW-1:0] REG_COEF_SP      = 4'd3;
    localparam logic [IDXW-1:0] REG_MAX_OUT      = 4'd4;
    localparam logic [IDXW-1:0] REG_NOISE_LEVEL  = 4'd5;
    localparam logic [IDXW-1:0] REG_GAIN_A       = 4'd6;
    localparam logic [IDXW-1:0] REG_GAIN_B       = 4'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_ERR,
        ST_SQ,
        ST_DEN_DIV,
        ST_GAIN,
        ST_UPD,
        ST_YD,
        ST_HOR,
        ST_NUM,
        ST_DRV_DIV,
        ST_FIN
    } state_t;

    // divider result towards the sequencer
    typedef struct packed {
        logic done;
        q_t   quot;
    } div_res_t;

    function automatic q_t sat32(acc_t v);
        q_t r;
        if (v > ACC_MAX)
            r = Q_MAX;
        else if (v < ACC_MIN)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic acc_t ext(q_t v);
        return {{16{v[31]}}, v};
    endfunction

endpackage

FILE: hdl/apc_mul.sv
module apc_mul (
    input  logic        clk,
    input  apc_pkg::q_t a,
    input  apc_pkg::q_t b,
    output apc_pkg::q_t p
);
    import apc_pkg::*;

    logic signed [63:0] prod_reg;

    // registered full product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // floor shift by the fraction width, then saturate
    assign p = sat32(prod_reg[63:16]);

endmodule

FILE: hdl/apc_div.sv
module apc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  apc_pkg::q_t      num,
    input  apc_pkg::q_t      den,
    output apc_pkg::div_res_t res
);
    import apc_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dmag_reg;
    logic [47:0] dvd_reg;
    logic [47:0] quo_reg;
    logic        neg_reg;
    q_t          quot_reg;

    logic [32:0] n33;
    logic [32:0] d33;
    logic [32:0] trial;
    logic        qbit;
    logic [31:0] rem_next;
    logic [47:0] quo_next;
    q_t          quot_next;

    // operand magnitudes
    always_comb
    begin
        n33 = {num[31], num};
        d33 = {den[31], den};
        if (num[31])
            n33 = -n33;
        if (den[31])
            d33 = -d33;
    end

    // one restoring step per cycle
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[47]};
        qbit     = (trial >= {1'b0, dmag_reg});
        rem_next = qbit ? 32'(trial - {1'b0, dmag_reg}) : trial[31:0];
        quo_next = {quo_reg[46:0], qbit};
        if (!neg_reg)
            quot_next = (quo_next > 48'h0000_7FFF_FFFF) ? Q_MAX : q_t'(quo_next[31:0]);
        else
            quot_next = (quo_next > 48'h0000_8000_0000) ? Q_MIN : q_t'(-quo_next[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvd_reg  <= {n33[31:0], 16'h0000};
            dmag_reg <= d33[31:0];
            neg_reg  <= num[31] ^ den[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvd_reg <= {dvd_reg[46:0], 1'b0};
            if (cnt_reg == 6'(DIV_STEPS - 1))
                quot_reg <= quot_next;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

FILE: hdl/adaptive_predictive_controller.sv
// Sequence: a warm-up sample goes straight to the result; an active sample runs prediction,
// adaptation with one divide, the horizon and a drive divide. Without adaptation there is one
// divide fewer, and the drive divide is skipped when h is zero.
// Throughput: one sample at a time; the shared multiplier and the one-bit-per-cycle divider
// limit it. A result may wait while the next is taken.
// Reset: asynchronous active low; estimates, histories and warm-up clear, registers default.
module adaptive_predictive_controller #(
    parameter int HORIZON    = 8,
    parameter int DELAY_A    = 1,
    parameter int DELAY_B    = 1,
    parameter int REF_OFFSET = 65536
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  apc_pkg::q_t              setpoint,
    input  apc_pkg::q_t              measured,
    output logic                     out_valid,
    input  logic                     out_ready,
    output apc_pkg::q_t              drive,
    output logic                     active,
    output logic                     adapted,
    input  logic                     cfg_write,
    input  logic [apc_pkg::IDXW-1:0] cfg_index,
    input  logic [31:0]              cfg_data
);
    import apc_pkg::*;

    localparam int YLEN     = DELAY_A + 2;
    localparam int ULEN     = DELAY_B + 3;
    localparam int WARM_END = DELAY_A + 10;
    localparam int JW       = (HORIZON > 2) ? $clog2(HORIZON) : 1;
    localparam acc_t REF_ACC = acc_t'(REF_OFFSET);
    localparam logic [4:0] WARM_END5 = 5'(WARM_END);

    state_t state_reg, state_next;
    logic [2:0]    op_reg;
    logic          ph_reg;
    logic [JW-1:0] j_reg;
    logic [4:0]    warm_reg;
    logic          active_reg, adapt_reg;

    q_t est_reg [5];
    q_t y_reg [YLEN];
    q_t u_reg [ULEN];
    q_t sp_prev_reg, ms_prev_reg;

    q_t          coef_y_reg, coef_y_prev_reg, coef_sp_prev_reg, coef_sp_reg;
    logic [30:0] max_out_reg, noise_reg, gain_a_reg, gain_b_reg;

    logic out_valid_reg, out_active_reg, out_adapted_reg;
    q_t   out_drive_reg;

    // working values of one sample
    q_t   sp_reg, ms_reg;
    acc_t acc_reg, h_reg;
    q_t   ek_reg, sa_reg, sb_reg, den_reg, q_reg, ka_reg, kb_reg, yd_reg;
    q_t   e1_reg, e2_reg, g2_reg, g3_reg, ne1_reg, num_reg, hq_reg, drv_reg;

    q_t        hist [5];
    q_t        mul_a, mul_b, pq;
    acc_t      pe, acc_sum, acc_dif;
    logic      div_start;
    q_t        div_n, div_d;
    div_res_t  div_res;
    logic [2:0] op_last;
    logic      mul_state, step_done, accept, slot_free;
    logic [4:0] warm_next;
    logic      active_now, adapt_now;
    q_t        yk, ek_now, hq_now, num_now, g1_now, mx, zero_drv, clamp_drv;
    logic signed [32:0] ek33;

    apc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (pq)
    );

    apc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .res   (div_res)
    );

    // history taps used by prediction and adaptation
    always_comb
    begin
        hist[0] = y_reg[DELAY_A];
        hist[1] = y_reg[DELAY_A + 1];
        hist[2] = u_reg[DELAY_B];
        hist[3] = u_reg[DELAY_B + 1];
        hist[4] = u_reg[DELAY_B + 2];
    end

    // shared helpers
    always_comb
    begin
        pe        = ext(pq);
        acc_sum   = acc_reg + pe;
        acc_dif   = acc_reg - pe;
        accept    = in_valid && in_ready;
        slot_free = !out_valid_reg || out_ready;
        warm_next = (warm_reg <= WARM_END5) ? warm_reg + 5'd1 : warm_reg;
        active_now = (warm_next >= WARM_END5);
        yk        = sat32(acc_reg);
        ek_now    = sat32(ext(y_reg[0]) - ext(yk));
        ek33      = {ek_now[31], ek_now};
        if (ek33 < 0)
            ek33 = -ek33;
        adapt_now = ($unsigned(ek33) > {2'b00, noise_reg});
        hq_now    = sat32(h_reg);
        num_now   = sat32(acc_dif);
        g1_now    = sat32(pe + ext(g2_reg));
        mx        = {1'b0, max_out_reg};
        if (num_now > 0)
            zero_drv = mx;
        else if (num_now < 0)
            zero_drv = -mx;
        else
            zero_drv = '0;
        if (div_res.quot > mx)
            clamp_drv = mx;
        else if (div_res.quot < -mx)
            clamp_drv = -mx;
        else
            clamp_drv = div_res.quot;
    end

    // last product index of each multiply phase
    always_comb
    begin
        mul_state = 1'b1;
        op_last   = 3'd0;
        case (state_reg)
            ST_PRED: op_last = 3'd4;
            ST_SQ:   op_last = 3'd6;
            ST_GAIN: op_last = 3'd1;
            ST_UPD:  op_last = 3'd4;
            ST_YD:   op_last = 3'd3;
            ST_HOR:  op_last = 3'd4;
            ST_NUM:  op_last = 3'd3;
            default: mul_state = 1'b0;
        endcase
        step_done = mul_state && ph_reg && (op_reg == op_last);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = active_now ? ST_PRED : ST_FIN;
            ST_PRED:
                if (step_done)
                    state_next = ST_ERR;
            ST_ERR:
                state_next = adapt_now ? ST_SQ : ST_YD;
            ST_SQ:
                if (step_done)
                    state_next = ST_DEN_DIV;
            ST_DEN_DIV:
                if (div_res.done)
                    state_next = ST_GAIN;
            ST_GAIN:
                if (step_done)
                    state_next = ST_UPD;
            ST_UPD:
                if (step_done)
                    state_next = ST_YD;
            ST_YD:
                if (step_done)
                    state_next = (HORIZON > 1) ? ST_HOR : ST_NUM;
            ST_HOR:
                if (step_done && (j_reg == JW'(HORIZON - 1)))
                    state_next = ST_NUM;
            ST_NUM:
                if (step_done)
                    state_next = (hq_now == '0) ? ST_FIN : ST_DRV_DIV;
            ST_DRV_DIV:
                if (div_res.done)
                    state_next = ST_FIN;
            ST_FIN:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and shared unit operands
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        div_start = ((state_reg == ST_DEN_DIV) || (state_reg == ST_DRV_DIV)) && !ph_reg;
        div_n     = (state_reg == ST_DEN_DIV) ? ek_reg : num_reg;
        div_d     = (state_reg == ST_DEN_DIV) ? den_reg : hq_reg;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_PRED:
            begin
                mul_a = est_reg[op_reg];
                mul_b = hist[op_reg];
            end
            ST_SQ:
                case (op_reg)
                    3'd5:
                    begin
                        mul_a = {1'b0, gain_a_reg};
                        mul_b = sa_reg;
                    end
                    3'd6:
                    begin
                        mul_a = {1'b0, gain_b_reg};
                        mul_b = sb_reg;
                    end
                    default:
                    begin
                        mul_a = hist[op_reg];
                        mul_b = hist[op_reg];
                    end
                endcase
            ST_GAIN:
            begin
                mul_a = (op_reg == 3'd0) ? {1'b0, gain_a_reg} : {1'b0, gain_b_reg};
                mul_b = q_reg;
            end
            ST_UPD:
            begin
                mul_a = (op_reg < 3'd2) ? ka_reg : kb_reg;
                mul_b = hist[op_reg];
            end
            ST_YD:
                case (op_reg)
                    3'd0:
                    begin
                        mul_a = coef_y_reg;
                        mul_b = ms_reg;
                    end
                    3'd1:
                    begin
                        mul_a = coef_y_prev_reg;
                        mul_b = ms_prev_reg;
                    end
                    3'd2:
                    begin
                        mul_a = coef_sp_prev_reg;
                        mul_b = sp_prev_reg;
                    end
                    default:
                    begin
                        mul_a = coef_sp_reg;
                        mul_b = sp_reg;
                    end
                endcase
            ST_HOR:
            begin
                mul_a = e1_reg;
                mul_b = est_reg[op_reg];
            end
            ST_NUM:
                case (op_reg)
                    3'd0:
                    begin
                        mul_a = e1_reg;
                        mul_b = y_reg[0];
                    end
                    3'd1:
                    begin
                        mul_a = e2_reg;
                        mul_b = y_reg[1];
                    end
                    3'd2:
                    begin
                        mul_a = g2_reg;
                        mul_b = u_reg[1];
                    end
                    default:
                    begin
                        mul_a = g3_reg;
                        mul_b = u_reg[2];
                    end
                endcase
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign drive     = out_drive_reg;
    assign active    = out_active_reg;
    assign adapted   = out_adapted_reg;

    // sequencer, model state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= '0;
            ph_reg           <= 1'b0;
            j_reg            <= '0;
            warm_reg         <= '0;
            active_reg       <= 1'b0;
            adapt_reg        <= 1'b0;
            est_reg          <= '{default: '0};
            y_reg            <= '{default: '0};
            u_reg            <= '{default: '0};
            sp_prev_reg      <= '0;
            ms_prev_reg      <= '0;
            coef_y_reg       <= '0;
            coef_y_prev_reg  <= '0;
            coef_sp_prev_reg <= '0;
            coef_sp_reg      <= 32'sd65536;
            max_out_reg      <= 31'd65536;
            noise_reg        <= '0;
            gain_a_reg       <= 31'd65536;
            gain_b_reg       <= 31'd65536;
            out_valid_reg    <= 1'b0;
            out_drive_reg    <= '0;
            out_active_reg   <= 1'b0;
            out_adapted_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // step counters
            if (state_next != state_reg)
            begin
                op_reg <= '0;
                ph_reg <= 1'b0;
                if (state_next == ST_HOR)
                    j_reg <= JW'(1);
            end
            else if (mul_state)
            begin
                ph_reg <= ~ph_reg;
                if (ph_reg)
                begin
                    if (op_reg == op_last)
                    begin
                        op_reg <= '0;
                        j_reg  <= j_reg + JW'(1);
                    end
                    else
                        op_reg <= op_reg + 3'd1;
                end
            end
            else if ((state_reg == ST_DEN_DIV) || (state_reg == ST_DRV_DIV))
                ph_reg <= 1'b1;

            // sample intake
            if (accept)
            begin
                warm_reg   <= warm_next;
                active_reg <= active_now;
                adapt_reg  <= 1'b0;
                y_reg[0]   <= sat32(ext(measured) + REF_ACC);
            end

            if (state_reg == ST_ERR)
                adapt_reg <= adapt_now;

            // estimate update
            if ((state_reg == ST_UPD) && ph_reg)
                est_reg[op_reg] <= sat32(ext(est_reg[op_reg]) + pe);

            // result and history shift
            if ((state_reg == ST_FIN) && slot_free)
            begin
                out_valid_reg   <= 1'b1;
                out_drive_reg   <= drv_reg;
                out_active_reg  <= active_reg;
                out_adapted_reg <= adapt_reg;
                for (int i = 1; i < YLEN; i++)
                    y_reg[i] <= y_reg[i - 1];
                for (int i = 2; i < ULEN; i++)
                    u_reg[i] <= u_reg[i - 1];
                u_reg[1] <= active_reg ? drv_reg : u_reg[0];
                if (active_reg)
                    u_reg[0] <= drv_reg;
                sp_prev_reg <= sp_reg;
                ms_prev_reg <= ms_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_COEF_Y:       coef_y_reg       <= cfg_data;
                    REG_COEF_Y_PREV:  coef_y_prev_reg  <= cfg_data;
                    REG_COEF_SP_PREV: coef_sp_prev_reg <= cfg_data;
                    REG_COEF_SP:      coef_sp_reg      <= cfg_data;
                    REG_MAX_OUT:      max_out_reg      <= cfg_data[30:0];
                    REG_NOISE_LEVEL:  noise_reg        <= cfg_data[30:0];
                    REG_GAIN_A:       gain_a_reg       <= cfg_data[30:0];
                    REG_GAIN_B:       gain_b_reg       <= cfg_data[30:0];
                    default:          ;
                endcase
            end
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sp_reg  <= setpoint;
            ms_reg  <= measured;
            drv_reg <= '0;
        end

        if (mul_state && ph_reg)
        begin
            case (state_reg)
                ST_PRED:
                    acc_reg <= (op_reg == 3'd0) ? pe : acc_sum;
                ST_SQ:
                    case (op_reg)
                        3'd0: acc_reg <= pe;
                        3'd1: sa_reg  <= sat32(acc_sum);
                        3'd2: acc_reg <= pe;
                        3'd3: acc_reg <= acc_sum;
                        3'd4: sb_reg  <= sat32(acc_sum);
                        3'd5: acc_reg <= ONE_ACC + pe;
                        default: den_reg <= sat32(acc_sum);
                    endcase
                ST_GAIN:
                    if (op_reg == 3'd0)
                        ka_reg <= pq;
                    else
                        kb_reg <= pq;
                ST_YD:
                begin
                    acc_reg <= (op_reg == 3'd0) ? REF_ACC + pe : acc_sum;
                    if (op_reg == 3'd3)
                    begin
                        yd_reg <= sat32(acc_sum);
                        e1_reg <= est_reg[0];
                        e2_reg <= est_reg[1];
                        g2_reg <= est_reg[3];
                        g3_reg <= est_reg[4];
                        h_reg  <= ext(est_reg[2]);
                    end
                end
                ST_HOR:
                    case (op_reg)
                        3'd0: ne1_reg <= sat32(pe + ext(e2_reg));
                        3'd1: e2_reg  <= pq;
                        3'd2: h_reg   <= h_reg + ext(g1_now);
                        3'd3: g2_reg  <= sat32(pe + ext(g3_reg));
                        default:
                        begin
                            g3_reg <= pq;
                            e1_reg <= ne1_reg;
                        end
                    endcase
                ST_NUM:
                begin
                    acc_reg <= (op_reg == 3'd0) ? ext(yd_reg) - pe : acc_dif;
                    if (op_reg == 3'd3)
                    begin
                        num_reg <= num_now;
                        hq_reg  <= hq_now;
                        drv_reg <= zero_drv;
                    end
                end
                default:
                    acc_reg <= acc_reg;
            endcase
        end

        if (state_reg == ST_ERR)
            ek_reg <= ek_now;

        if ((state_reg == ST_DEN_DIV) && div_res.done)
            q_reg <= div_res.quot;

        if ((state_reg == ST_DRV_DIV) && div_res.done)
            drv_reg <= clamp_drv;
    end

endmodule

FILE: bench/tb_top.sv
// Scoreboard: predicts each control sample and checks each result in order
class apc_scoreboard;
    typedef struct packed {
        logic signed [31:0] drive;
        logic               active;
        logic               adapted;
    } ctl_res_t;

    // controller state
    longint coef_y, coef_y_prev, coef_sp_prev, coef_sp;
    longint max_out, noise_level, gain_a, gain_b;
    longint est[5];
    longint yh[3];
    longint uh[4];
    longint sp_prev, ms_prev;
    int     warm;
    ctl_res_t pending[$];
    int     errors;

    function new();
        coef_y = 0; coef_y_prev = 0; coef_sp_prev = 0; coef_sp = 65536;
        max_out = 65536; noise_level = 0; gain_a = 65536; gain_b = 65536;
        foreach (est[i]) est[i] = 0;
        foreach (yh[i]) yh[i] = 0;
        foreach (uh[i]) uh[i] = 0;
        sp_prev = 0; ms_prev = 0; warm = 0; errors = 0;
    endfunction

    function longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b/2^16), saturated
    function longint fmul(longint a, longint b);
        longint p;
        p = a * b;
        return sat(p >>> 16);
    endfunction

    function longint fdiv(longint n, longint d);
        return (n * 65536) / d;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
        case (idx)
            apc_pkg::REG_COEF_Y:       coef_y = longint'(signed'(v));
            apc_pkg::REG_COEF_Y_PREV:  coef_y_prev = longint'(signed'(v));
            apc_pkg::REG_COEF_SP_PREV: coef_sp_prev = longint'(signed'(v));
            apc_pkg::REG_COEF_SP:      coef_sp = longint'(signed'(v));
            apc_pkg::REG_MAX_OUT:      max_out = longint'(v[30:0]);
            apc_pkg::REG_NOISE_LEVEL:  noise_level = longint'(v[30:0]);
            apc_pkg::REG_GAIN_A:       gain_a = longint'(v[30:0]);
            apc_pkg::REG_GAIN_B:       gain_b = longint'(v[30:0]);
            default: ;
        endcase
    endfunction

    // work out the result of one accepted sample
    function void note_sample(logic signed [31:0] sp_in, logic signed [31:0] ms_in);
        longint sp, ms, ya, yb, ua, ub, uc, yk, ek, yd, num, h;
        longint e1, e2, g1, g2, g3, ne1, ne2, ng1, ng2, ng3;
        longint sa, sb, den, q, ka, kb, drv;
        bit act, adp;
        ctl_res_t r;
        sp = sp_in; ms = ms_in; drv = 0; adp = 0;
        if (warm <= 11) warm++;
        act = warm >= 11;
        yh[0] = sat(ms + 65536);
        if (act) begin
            ya = yh[1]; yb = yh[2]; ua = uh[1]; ub = uh[2]; uc = uh[3];
            yk = sat(fmul(est[0], ya) + fmul(est[1], yb) + fmul(est[2], ua)
                     + fmul(est[3], ub) + fmul(est[4], uc));
            ek = sat(yh[0] - yk);
            adp = ((ek < 0) ? -ek : ek) > noise_level;
            if (adp) begin
                sa = sat(fmul(ya, ya) + fmul(yb, yb));
                sb = sat(fmul(ua, ua) + fmul(ub, ub) + fmul(uc, uc));
                den = sat(65536 + fmul(gain_a, sa) + fmul(gain_b, sb));
                q = sat(fdiv(ek, den));
                ka = fmul(gain_a, q); kb = fmul(gain_b, q);
                est[0] = sat(est[0] + fmul(ka, ya));
                est[1] = sat(est[1] + fmul(ka, yb));
                est[2] = sat(est[2] + fmul(kb, ua));
                est[3] = sat(est[3] + fmul(kb, ub));
                est[4] = sat(est[4] + fmul(kb, uc));
            end
            yd = sat(fmul(coef_y, ms) + fmul(coef_y_prev, ms_prev)
                     + fmul(coef_sp_prev, sp_prev) + fmul(coef_sp, sp) + 65536);
            e1 = est[0]; e2 = est[1]; g1 = est[2]; g2 = est[3]; g3 = est[4];
            h = g1;
            for (int j = 1; j < 8; j++) begin
                ne1 = sat(fmul(e1, est[0]) + e2);
                ne2 = fmul(e1, est[1]);
                ng1 = sat(fmul(e1, est[2]) + g2);
                ng2 = sat(fmul(e1, est[3]) + g3);
                ng3 = fmul(e1, est[4]);
                e1 = ne1; e2 = ne2; g1 = ng1; g2 = ng2; g3 = ng3;
                h += g1;
            end
            h = sat(h);
            num = sat(yd - fmul(e1, yh[0]) - fmul(e2, yh[1])
                      - fmul(g2, uh[1]) - fmul(g3, uh[2]));
            if (h == 0)
                drv = (num > 0) ? max_out : ((num < 0) ? -max_out : 0);
            else begin
                drv = fdiv(num, h);
                if (drv > max_out) drv = max_out;
                else if (drv < -max_out) drv = -max_out;
            end
            uh[0] = drv;
        end
        for (int i = 2; i > 0; i--) yh[i] = yh[i-1];
        for (int i = 3; i > 0; i--) uh[i] = uh[i-1];
        sp_prev = sp; ms_prev = ms;
        r.drive = drv[31:0]; r.active = act; r.adapted = adp;
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] d, logic a, logic p);
        ctl_res_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result drive=%0d", $time, d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d !== e.drive) begin
            $display("%0t: drive expected %0d actual %0d", $time, e.drive, d);
            errors++;
        end
        if (a !== e.active) begin
            $display("%0t: active expected %0b actual %0b", $time, e.active, a);
            errors++;
        end
        if (p !== e.adapted) begin
            $display("%0t: adapted expected %0b actual %0b", $time, e.adapted, p);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import apc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    q_t          setpoint = '0;
    q_t          measured = '0;
    logic        out_valid;
    logic        out_ready = 0;
    q_t          drive;
    logic        active;
    logic        adapted;
    logic        cfg_write = 0;
    logic [IDXW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          quiet = 0;
    apc_scoreboard board;

    adaptive_predictive_controller i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .setpoint(setpoint), .measured(measured),
        .out_valid(out_valid), .out_ready(out_ready),
        .drive(drive), .active(active), .adapted(adapted),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, checks each accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(drive, active, adapted);
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays up between back-to-back requests; idle gaps drop it
    task automatic send_sample(logic [31:0] sp, logic [31:0] ms);
        cfg_write <= 0;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_valid <= 1;
        setpoint <= sp;
        measured <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_sample(sp, ms);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // write enable is dropped by the next request
    task automatic write_reg(int idx, logic [31:0] v);
        cfg_write <= 1;
        cfg_index <= idx[IDXW-1:0];
        cfg_data <= v;
        @(posedge clk);
        board.write_reg(idx, v);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $signed($urandom_range(262143)) - 131072;
        endcase
    endfunction

    // one full register setting; extremes at times
    task automatic random_setting(bit wild);
        for (int i = 0; i < 8; i++)
            write_reg(i, wild ? rand_q() : ($urandom_range(131072) - 32768));
        write_reg(REG_MAX_OUT, wild ? $urandom : $urandom_range(400000));
        write_reg(REG_NOISE_LEVEL, $urandom_range(3) == 0 ? $urandom : $urandom_range(8000));
        write_reg(REG_GAIN_A, wild ? $urandom : $urandom_range(70000));
        write_reg(REG_GAIN_B, wild ? $urandom : $urandom_range(70000));
    endtask

    initial
    begin
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: warm-up, field extremes, zero divisor with default estimates
        send_idle = 0; recv_idle = 0;
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000);
        for (int i = 0; i < 12; i++)
            send_sample(i * 32'h1_0000, 32'h0);
        send_sample(32'h0, 32'hFFFF_0000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        // noise level at its top: adaptation only on a full-scale negative error; ignored index and wide data
        write_reg(REG_NOISE_LEVEL, 32'hFFFF_FFFF);
        write_reg(8, 32'h1234_5678);
        write_reg(15, 32'hFFFF_FFFF);
        write_reg(REG_MAX_OUT, 32'h0);
        for (int i = 0; i < 4; i++)
            send_sample(rand_q(), rand_q());
        drain();
        write_reg(REG_MAX_OUT, 32'hFFFF_FFFF);
        write_reg(REG_NOISE_LEVEL, 32'h0);
        for (int i = 0; i < 4; i++)
            send_sample(rand_q(), rand_q());
        drain();

        // random phases over three idling regimes
        for (int ph = 0; ph < 24; ph++)
        begin
            if (ph < 8) begin send_idle = 35; recv_idle = 72; end
            else if (ph < 16) begin send_idle = 72; recv_idle = 35; end
            else begin send_idle = 0; recv_idle = 0; end
            random_setting(ph % 4 == 3);
            for (int i = 0; i < 47; i++)
                send_sample(rand_q(), rand_q());
            drain();
        end

        drain();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/apc_pkg.sv
hdl/apc_mul.sv
hdl/apc_div.sv
hdl/adaptive_predictive_controller.sv
bench/tb_top.sv
